// ----- src/cpt_pkg.sv -----
// Shared types and constants for the closest-point-on-triangle block.
// No dependencies; imported by every module of the block.
package cpt_pkg;

    localparam int COORD_WIDTH = 16;
    localparam int CFG_W       = 48;
    localparam int CFG_IDX_W   = 2;
    localparam int EXT_W       = (3 * COORD_WIDTH > CFG_W) ? 3 * COORD_WIDTH : CFG_W;

    localparam int DIFF_W  = COORD_WIDTH + 1;
    localparam int PROD_W  = 2 * DIFF_W;
    localparam int DOT_W   = PROD_W + 2;
    localparam int LO_W    = DOT_W / 2;
    localparam int HI_W    = DOT_W - LO_W;
    localparam int PP_W    = DOT_W + 2;
    localparam int M_W     = 2 * DOT_W;
    localparam int V_W     = M_W + 1;
    localparam int DEN_W   = V_W + 2;
    localparam int CH_W    = (V_W + 2) / 3;
    localparam int CHX_W   = 3 * CH_W;
    localparam int PN_W    = DIFF_W + CH_W + 1;
    localparam int NUM_W   = DIFF_W + V_W + 1;
    localparam int QB      = COORD_WIDTH + 2;
    localparam int MAG_W   = QB + 1;
    localparam int DVS_W   = DEN_W + 1;
    localparam int CMP_W   = (NUM_W + 2 > DVS_W + QB) ? NUM_W + 2 : DVS_W + QB;
    localparam int SUM_W   = COORD_WIDTH + 4;

    localparam int Q_DEPTH   = 8;
    localparam int Q_AW      = $clog2(Q_DEPTH);
    localparam int FRONT_LAT = 6;

    typedef enum logic [2:0] {
        REG_VA  = 3'd0,
        REG_VB  = 3'd1,
        REG_EAB = 3'd2,
        REG_VC  = 3'd3,
        REG_EAC = 3'd4,
        REG_EBC = 3'd5,
        REG_IN  = 3'd6
    } region_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_VA = 2'd0,
        CFG_VB = 2'd1,
        CFG_VC = 2'd2
    } cfg_idx_t;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic [2:0][COORD_WIDTH-1:0]   vec_t;

    typedef struct packed {
        vec_t a;
        vec_t b;
        vec_t c;
    } tri_t;

    typedef struct packed {
        region_t                  region;
        logic                     weighted;
        logic signed [V_W-1:0]    n1;
        logic signed [V_W-1:0]    n2;
        logic signed [DEN_W-1:0]  den;
    } job_t;

    typedef struct packed {
        logic push;
        job_t job;
    } push_t;

endpackage

// ----- src/cpt_front.sv -----
// Front end: latches a query, forms the six dot products and the three
// barycentric cross terms, classifies the region. Uses cpt_pkg.
module cpt_front
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            accept,
    input  cpt_pkg::coord_t point_x,
    input  cpt_pkg::coord_t point_y,
    input  cpt_pkg::coord_t point_z,
    input  cpt_pkg::tri_t   geo,
    output cpt_pkg::push_t  fq
);
    import cpt_pkg::*;

    logic signed [DIFF_W-1:0] ab [3];
    logic signed [DIFF_W-1:0] ac [3];
    coord_t                   pt [3];

    logic [FRONT_LAT-1:0]     vld_reg;

    logic signed [DIFF_W-1:0] ap_reg [3];
    logic signed [DIFF_W-1:0] bp_reg [3];
    logic signed [DIFF_W-1:0] cp_reg [3];
    logic signed [PROD_W-1:0] prod_reg [6][3];
    logic signed [DOT_W-1:0]  d_reg [6];
    logic signed [DOT_W-1:0]  d4_reg [6];
    logic signed [DOT_W-1:0]  d5_reg [6];
    logic signed [DOT_W-1:0]  d6_reg [6];

    logic signed [DOT_W-1:0]  ma [6];
    logic signed [DOT_W-1:0]  mb [6];
    logic signed [HI_W-1:0]   ah [6];
    logic signed [HI_W-1:0]   bh [6];
    logic signed [LO_W:0]     al [6];
    logic signed [LO_W:0]     bl [6];
    logic signed [PP_W-1:0]   hh_reg [6];
    logic signed [PP_W-1:0]   hl_reg [6];
    logic signed [PP_W-1:0]   lh_reg [6];
    logic signed [PP_W-1:0]   ll_reg [6];
    logic signed [M_W-1:0]    m_reg [6];
    logic signed [V_W-1:0]    va_reg;
    logic signed [V_W-1:0]    vb_reg;
    logic signed [V_W-1:0]    vc_reg;

    logic signed [DOT_W:0]    e43;
    logic signed [DOT_W:0]    e56;
    job_t                     job;

    assign pt[0] = point_x;
    assign pt[1] = point_y;
    assign pt[2] = point_z;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            ab[i] = DIFF_W'($signed(geo.b[i])) - DIFF_W'($signed(geo.a[i]));
            ac[i] = DIFF_W'($signed(geo.c[i])) - DIFF_W'($signed(geo.a[i]));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[FRONT_LAT-2:0], accept};
        end
    end

    // offsets of the query from each vertex
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int i = 0; i < 3; i++)
            begin
                ap_reg[i] <= DIFF_W'(pt[i]) - DIFF_W'($signed(geo.a[i]));
                bp_reg[i] <= DIFF_W'(pt[i]) - DIFF_W'($signed(geo.b[i]));
                cp_reg[i] <= DIFF_W'(pt[i]) - DIFF_W'($signed(geo.c[i]));
            end
        end
    end

    // d1..d6 products and sums
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            prod_reg[0][i] <= ab[i] * ap_reg[i];
            prod_reg[1][i] <= ac[i] * ap_reg[i];
            prod_reg[2][i] <= ab[i] * bp_reg[i];
            prod_reg[3][i] <= ac[i] * bp_reg[i];
            prod_reg[4][i] <= ab[i] * cp_reg[i];
            prod_reg[5][i] <= ac[i] * cp_reg[i];
        end
        for (int k = 0; k < 6; k++)
        begin
            d_reg[k] <= DOT_W'(prod_reg[k][0]) + DOT_W'(prod_reg[k][1])
                      + DOT_W'(prod_reg[k][2]);
        end
    end

    // cross terms: vc = d1*d4 - d3*d2, vb = d5*d2 - d1*d6, va = d3*d6 - d5*d4
    always_comb
    begin
        ma[0] = d_reg[0]; mb[0] = d_reg[3];
        ma[1] = d_reg[2]; mb[1] = d_reg[1];
        ma[2] = d_reg[4]; mb[2] = d_reg[1];
        ma[3] = d_reg[0]; mb[3] = d_reg[5];
        ma[4] = d_reg[2]; mb[4] = d_reg[5];
        ma[5] = d_reg[4]; mb[5] = d_reg[3];
        for (int j = 0; j < 6; j++)
        begin
            ah[j] = ma[j][DOT_W-1:LO_W];
            bh[j] = mb[j][DOT_W-1:LO_W];
            al[j] = {1'b0, ma[j][LO_W-1:0]};
            bl[j] = {1'b0, mb[j][LO_W-1:0]};
        end
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < 6; j++)
        begin
            hh_reg[j] <= ah[j] * bh[j];
            hl_reg[j] <= ah[j] * bl[j];
            lh_reg[j] <= al[j] * bh[j];
            ll_reg[j] <= al[j] * bl[j];
            m_reg[j]  <= (M_W'(hh_reg[j]) <<< (2 * LO_W))
                       + ((M_W'(hl_reg[j]) + M_W'(lh_reg[j])) <<< LO_W)
                       + M_W'(ll_reg[j]);
        end
        vc_reg <= V_W'(m_reg[0]) - V_W'(m_reg[1]);
        vb_reg <= V_W'(m_reg[2]) - V_W'(m_reg[3]);
        va_reg <= V_W'(m_reg[4]) - V_W'(m_reg[5]);
        d4_reg <= d_reg;
        d5_reg <= d4_reg;
        d6_reg <= d5_reg;
    end

    // region select
    always_comb
    begin
        e43          = (DOT_W+1)'(d6_reg[3]) - (DOT_W+1)'(d6_reg[2]);
        e56          = (DOT_W+1)'(d6_reg[4]) - (DOT_W+1)'(d6_reg[5]);
        job.region   = REG_VA;
        job.weighted = 1'b0;
        job.n1       = '0;
        job.n2       = '0;
        job.den      = DEN_W'(1);
        priority if (d6_reg[0] <= 0 && d6_reg[1] <= 0)
        begin
            job.region = REG_VA;
        end
        else if (d6_reg[2] >= 0 && d6_reg[3] <= d6_reg[2])
        begin
            job.region = REG_VB;
        end
        else if (vc_reg <= 0 && d6_reg[0] >= 0 && d6_reg[2] <= 0)
        begin
            job.region   = REG_EAB;
            job.weighted = 1'b1;
            job.n1       = V_W'(d6_reg[0]);
            job.den      = DEN_W'(d6_reg[0]) - DEN_W'(d6_reg[2]);
        end
        else if (d6_reg[5] >= 0 && d6_reg[4] <= d6_reg[5])
        begin
            job.region = REG_VC;
        end
        else if (vb_reg <= 0 && d6_reg[1] >= 0 && d6_reg[5] <= 0)
        begin
            job.region   = REG_EAC;
            job.weighted = 1'b1;
            job.n1       = V_W'(d6_reg[1]);
            job.den      = DEN_W'(d6_reg[1]) - DEN_W'(d6_reg[5]);
        end
        else if (va_reg <= 0 && e43 >= 0 && e56 >= 0)
        begin
            job.region   = REG_EBC;
            job.weighted = 1'b1;
            job.n1       = V_W'(e43);
            job.den      = DEN_W'(e43) + DEN_W'(e56);
        end
        else
        begin
            job.region   = REG_IN;
            job.weighted = 1'b1;
            job.n1       = vb_reg;
            job.n2       = vc_reg;
            job.den      = DEN_W'(va_reg) + DEN_W'(vb_reg) + DEN_W'(vc_reg);
        end
    end

    assign fq.push = vld_reg[FRONT_LAT-1];
    assign fq.job  = job;

`ifndef SYNTHESIS
    a_lat : assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> ##(FRONT_LAT-1) fq.push)
        else $error("request lost in front pipeline");
    a_vtx : assert property (@(posedge clk) disable iff (!rst_n)
        fq.push && (fq.job.region == REG_VA || fq.job.region == REG_VB
                    || fq.job.region == REG_VC) |-> !fq.job.weighted)
        else $error("vertex region marked weighted");
    a_n2 : assert property (@(posedge clk) disable iff (!rst_n)
        fq.push && fq.job.region != REG_IN |-> fq.job.n2 == '0)
        else $error("second weight set outside interior");
`endif

endmodule

// ----- src/cpt_queue.sv -----
// Short job queue between front and back ends, registered read.
// Uses cpt_pkg.
module cpt_queue
(
    input  logic           clk,
    input  logic           rst_n,
    input  cpt_pkg::push_t fq,
    output logic           take,
    output cpt_pkg::job_t  job,
    output logic           busy
);
    import cpt_pkg::*;

    job_t             mem [Q_DEPTH];
    logic [Q_AW-1:0]  wr_ptr_reg;
    logic [Q_AW-1:0]  rd_ptr_reg;
    logic [Q_AW:0]    count_reg;
    logic [Q_AW:0]    count_next;
    logic             pop;
    logic             take_reg;
    job_t             job_reg;

    assign pop = (count_reg != '0);

    always_comb
    begin
        count_next = count_reg;
        if (fq.push && !pop)
            count_next = count_reg + 1'b1;
        else if (!fq.push && pop)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
            take_reg   <= 1'b0;
        end
        else
        begin
            if (fq.push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
            take_reg  <= pop;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fq.push)
            mem[wr_ptr_reg] <= fq.job;
        if (pop)
            job_reg <= mem[rd_ptr_reg];
    end

    // hold off new requests while the front could still overrun the queue
    assign busy = (count_reg >= (Q_AW+1)'(Q_DEPTH - FRONT_LAT));
    assign take = take_reg;
    assign job  = job_reg;

`ifndef SYNTHESIS
    a_ovf : assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == (Q_AW+1)'(Q_DEPTH) |-> !fq.push)
        else $error("queue overflow");
    a_pop : assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> take)
        else $error("popped entry not delivered");
    a_lvl : assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (Q_AW+1)'(Q_DEPTH))
        else $error("queue level out of range");
`endif

endmodule

// ----- src/cpt_back.sv -----
// Back end: weighted offsets, rounding divider pipeline, clamp and result
// register. Uses cpt_pkg.
module cpt_back
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            take,
    input  cpt_pkg::job_t   job,
    input  cpt_pkg::tri_t   geo,
    output logic            done,
    output cpt_pkg::coord_t near_x,
    output cpt_pkg::coord_t near_y,
    output cpt_pkg::coord_t near_z,
    output logic [2:0]      region,
    output logic            degenerate
);
    import cpt_pkg::*;

    typedef struct packed {
        region_t region;
        logic    deg;
        logic    wt;
        vec_t    base;
    } info_t;

    logic signed [DIFF_W-1:0] ab [3];
    logic signed [DIFF_W-1:0] ac [3];
    logic signed [DIFF_W-1:0] bc [3];
    logic signed [DIFF_W-1:0] dir1 [3];
    logic signed [CHX_W-1:0]  n1x;
    logic signed [CHX_W-1:0]  n2x;
    logic signed [CH_W:0]     n1c [3];
    logic signed [CH_W:0]     n2c [3];
    logic signed [DEN_W-1:0]  den_s;
    logic                     den_zero;
    info_t                    info1;

    logic                     vb1_reg;
    logic                     vb2_reg;
    logic                     vb3_reg;
    info_t                    info1_reg;
    info_t                    info2_reg;
    info_t                    info3_reg;
    logic signed [PN_W-1:0]   pp_reg [3][2][3];
    logic [DEN_W-1:0]         dabs1_reg;
    logic [DEN_W-1:0]         dabs2_reg;
    logic [DEN_W-1:0]         dabs3_reg;
    logic                     dneg1_reg;
    logic                     dneg2_reg;
    logic signed [NUM_W-1:0]  num_reg [3];
    logic [NUM_W-1:0]         nabs_reg [3];
    logic [2:0]               neg3_reg;

    logic [QB:0]              vp_reg;
    info_t                    infop_reg [QB+1];
    logic [2:0]               negp_reg [QB+1];
    logic [2:0]               satp_reg [QB+1];
    logic [DVS_W-1:0]         dvp_reg [QB+1];
    logic [CMP_W-1:0]         remp_reg [QB+1][3];
    logic [QB-1:0]            qp_reg [QB+1][3];

    logic [CMP_W-1:0]         n2w [3];
    logic [DVS_W-1:0]         dv0;

    logic [MAG_W-1:0]         mag [3];
    logic signed [SUM_W-1:0]  off [3];
    logic signed [SUM_W-1:0]  tot [3];
    coord_t                   res [3];

    logic                     done_reg;
    coord_t                   near_reg [3];
    region_t                  region_reg;
    logic                     deg_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            ab[i] = DIFF_W'($signed(geo.b[i])) - DIFF_W'($signed(geo.a[i]));
            ac[i] = DIFF_W'($signed(geo.c[i])) - DIFF_W'($signed(geo.a[i]));
            bc[i] = DIFF_W'($signed(geo.c[i])) - DIFF_W'($signed(geo.b[i]));
        end
    end

    // stage 1: operand select and partial products
    always_comb
    begin
        den_s      = $signed(job.den);
        den_zero   = (den_s == 0);
        info1.region = job.region;
        info1.deg  = job.weighted && den_zero;
        info1.wt   = job.weighted && !den_zero;
        info1.base = geo.a;
        if (!info1.deg)
        begin
            unique case (job.region)
                REG_VB, REG_EBC: info1.base = geo.b;
                REG_VC:          info1.base = geo.c;
                default:         info1.base = geo.a;
            endcase
        end
        for (int i = 0; i < 3; i++)
        begin
            unique case (job.region)
                REG_EAC: dir1[i] = ac[i];
                REG_EBC: dir1[i] = bc[i];
                default: dir1[i] = ab[i];
            endcase
        end
        n1x    = CHX_W'($signed(job.n1));
        n2x    = CHX_W'($signed(job.n2));
        n1c[0] = {1'b0, n1x[CH_W-1:0]};
        n1c[1] = {1'b0, n1x[2*CH_W-1:CH_W]};
        n1c[2] = (CH_W+1)'($signed(n1x[3*CH_W-1:2*CH_W]));
        n2c[0] = {1'b0, n2x[CH_W-1:0]};
        n2c[1] = {1'b0, n2x[2*CH_W-1:CH_W]};
        n2c[2] = (CH_W+1)'($signed(n2x[3*CH_W-1:2*CH_W]));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vb1_reg  <= 1'b0;
            vb2_reg  <= 1'b0;
            vb3_reg  <= 1'b0;
            vp_reg   <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            vb1_reg  <= take;
            vb2_reg  <= vb1_reg;
            vb3_reg  <= vb2_reg;
            vp_reg   <= {vp_reg[QB-1:0], vb3_reg};
            done_reg <= vp_reg[QB];
        end
    end

    always_ff @(posedge clk)
    begin
        info1_reg <= info1;
        dneg1_reg <= den_s[DEN_W-1];
        dabs1_reg <= den_s[DEN_W-1] ? DEN_W'(-den_s) : DEN_W'(den_s);
        for (int i = 0; i < 3; i++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                pp_reg[i][0][c] <= dir1[i] * n1c[c];
                pp_reg[i][1][c] <= ac[i] * n2c[c];
            end
        end
    end

    // stage 2: numerator sum; stage 3: magnitude and sign
    always_ff @(posedge clk)
    begin
        info2_reg <= info1_reg;
        dabs2_reg <= dabs1_reg;
        dneg2_reg <= dneg1_reg;
        for (int i = 0; i < 3; i++)
        begin
            num_reg[i] <= (NUM_W'(pp_reg[i][0][0]) + NUM_W'(pp_reg[i][1][0]))
                        + ((NUM_W'(pp_reg[i][0][1]) + NUM_W'(pp_reg[i][1][1])) <<< CH_W)
                        + ((NUM_W'(pp_reg[i][0][2]) + NUM_W'(pp_reg[i][1][2]))
                           <<< (2 * CH_W));
        end
        info3_reg <= info2_reg;
        dabs3_reg <= dabs2_reg;
        for (int i = 0; i < 3; i++)
        begin
            nabs_reg[i] <= num_reg[i][NUM_W-1] ? NUM_W'(-num_reg[i]) : NUM_W'(num_reg[i]);
            neg3_reg[i] <= num_reg[i][NUM_W-1] ^ dneg2_reg;
        end
    end

    // divider: round(|n|/|d|) = floor((2|n| + |d|) / 2|d|), one quotient bit per stage
    always_comb
    begin
        dv0 = {dabs3_reg, 1'b0};
        for (int i = 0; i < 3; i++)
        begin
            n2w[i] = CMP_W'({nabs_reg[i], 1'b0}) + CMP_W'(dabs3_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        infop_reg[0] <= info3_reg;
        negp_reg[0]  <= neg3_reg;
        dvp_reg[0]   <= dv0;
        for (int i = 0; i < 3; i++)
        begin
            remp_reg[0][i] <= n2w[i];
            qp_reg[0][i]   <= '0;
            satp_reg[0][i] <= (n2w[i] >= (CMP_W'(dv0) << QB));
        end
        for (int s = 0; s < QB; s++)
        begin
            infop_reg[s+1] <= infop_reg[s];
            negp_reg[s+1]  <= negp_reg[s];
            satp_reg[s+1]  <= satp_reg[s];
            dvp_reg[s+1]   <= dvp_reg[s];
            for (int i = 0; i < 3; i++)
            begin
                if (remp_reg[s][i] >= (CMP_W'(dvp_reg[s]) << (QB - 1 - s)))
                begin
                    remp_reg[s+1][i] <= remp_reg[s][i]
                                      - (CMP_W'(dvp_reg[s]) << (QB - 1 - s));
                    qp_reg[s+1][i]   <= qp_reg[s][i] | (QB'(1) << (QB - 1 - s));
                end
                else
                begin
                    remp_reg[s+1][i] <= remp_reg[s][i];
                    qp_reg[s+1][i]   <= qp_reg[s][i];
                end
            end
        end
    end

    // offset, add to base, saturate
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            mag[i] = satp_reg[QB][i] ? (MAG_W'(1) << QB) : MAG_W'(qp_reg[QB][i]);
            off[i] = negp_reg[QB][i] ? -$signed(SUM_W'(mag[i])) : $signed(SUM_W'(mag[i]));
            if (!infop_reg[QB].wt)
                off[i] = '0;
            tot[i] = SUM_W'($signed(infop_reg[QB].base[i])) + off[i];
            if (tot[i][SUM_W-1:COORD_WIDTH-1] == '0
                || tot[i][SUM_W-1:COORD_WIDTH-1] == '1)
                res[i] = tot[i][COORD_WIDTH-1:0];
            else if (tot[i][SUM_W-1])
                res[i] = {1'b1, {(COORD_WIDTH-1){1'b0}}};
            else
                res[i] = {1'b0, {(COORD_WIDTH-1){1'b1}}};
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
            near_reg[i] <= res[i];
        region_reg <= infop_reg[QB].region;
        deg_reg    <= infop_reg[QB].deg;
    end

    assign done       = done_reg;
    assign near_x     = near_reg[0];
    assign near_y     = near_reg[1];
    assign near_z     = near_reg[2];
    assign region     = region_reg;
    assign degenerate = deg_reg;

`ifndef SYNTHESIS
    a_lat : assert property (@(posedge clk) disable iff (!rst_n)
        vb1_reg |-> ##(QB+4) done_reg)
        else $error("request lost in back pipeline");
    a_deg : assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && deg_reg |-> region_reg == REG_EAB || region_reg == REG_EAC
                                || region_reg == REG_EBC || region_reg == REG_IN)
        else $error("degenerate flag on vertex region");
    a_rem : assert property (@(posedge clk) disable iff (!rst_n)
        vp_reg[QB] && infop_reg[QB].wt && !satp_reg[QB][0]
            |-> remp_reg[QB][0] < CMP_W'(dvp_reg[QB]))
        else $error("divider remainder out of range");
`endif

endmodule

// ----- src/closest_point_on_triangle.sv -----
// Top level of the closest-point-on-triangle block: configuration registers,
// front end, job queue and back end. Uses cpt_pkg, cpt_front, cpt_queue, cpt_back.
//
// Closest point on a triangle with its Voronoi region. Write the vertices a, b, c
// through the cfg port (index 0..2, coordinates packed x/y/z, signed Q8.8), only
// while no query is in flight. A query is taken when start is high and busy is low;
// one query can be taken every cycle. Each query gives exactly one result, shown
// for one cycle with done high, in request order. The path has six front stages
// for dot and cross products, two for the queue, and a back end whose length is
// set by the rounding divider, one quotient bit per stage. Results are rounded to
// nearest and saturated; a zero divisor returns vertex a with degenerate set.
// There is no result backpressure.
module closest_point_on_triangle
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  cpt_pkg::coord_t                 point_x,
    input  cpt_pkg::coord_t                 point_y,
    input  cpt_pkg::coord_t                 point_z,
    output logic                            done,
    output cpt_pkg::coord_t                 near_x,
    output cpt_pkg::coord_t                 near_y,
    output cpt_pkg::coord_t                 near_z,
    output logic [2:0]                      region,
    output logic                            degenerate,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [cpt_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [cpt_pkg::CFG_W-1:0]       cfg_data
);
    import cpt_pkg::*;

    logic [CFG_W-1:0] va_reg;
    logic [CFG_W-1:0] vb_reg;
    logic [CFG_W-1:0] vc_reg;
    logic [EXT_W-1:0] ext_a;
    logic [EXT_W-1:0] ext_b;
    logic [EXT_W-1:0] ext_c;
    tri_t             geo;
    logic             accept;
    push_t            fq;
    logic             take;
    job_t             job;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= '0;
            vb_reg <= '0;
            vc_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_VA:  va_reg <= cfg_data;
                CFG_VB:  vb_reg <= cfg_data;
                CFG_VC:  vc_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        ext_a = EXT_W'(va_reg);
        ext_b = EXT_W'(vb_reg);
        ext_c = EXT_W'(vc_reg);
        for (int i = 0; i < 3; i++)
        begin
            geo.a[i] = ext_a[i*COORD_WIDTH +: COORD_WIDTH];
            geo.b[i] = ext_b[i*COORD_WIDTH +: COORD_WIDTH];
            geo.c[i] = ext_c[i*COORD_WIDTH +: COORD_WIDTH];
        end
    end

    assign accept = start && !busy;

    cpt_front u_front
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .point_x (point_x),
        .point_y (point_y),
        .point_z (point_z),
        .geo     (geo),
        .fq      (fq)
    );

    cpt_queue u_queue
    (
        .clk   (clk),
        .rst_n (rst_n),
        .fq    (fq),
        .take  (take),
        .job   (job),
        .busy  (busy)
    );

    cpt_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .take       (take),
        .job        (job),
        .geo        (geo),
        .done       (done),
        .near_x     (near_x),
        .near_y     (near_y),
        .near_z     (near_z),
        .region     (region),
        .degenerate (degenerate)
    );

endmodule
